@@ rtl/cubic_bezier_segmenter_core_macros.svh @@
// Assertion macros shared by the cubic Bezier segmenter RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef CUBIC_BEZIER_SEGMENTER_CORE_MACROS_SVH
`define CUBIC_BEZIER_SEGMENTER_CORE_MACROS_SVH

// Condition and consequence in the same cycle.
`define CBS_ASSERT_SAME(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Consequence in the cycle after the condition.
`define CBS_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

@@ rtl/cbs_pkg.sv @@
// Shared types and constants of the cubic Bezier segmenter.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package cbs_pkg;

	localparam int MAX_SEGMENTS_DEF = 64;
	localparam int COORD_WIDTH_DEF  = 32;
	localparam int FRAC_BITS_DEF    = 16;

	localparam int              CFG_WIDTH       = 7;
	localparam logic [CFG_WIDTH-1:0] SEG_COUNT_RESET = 7'd16;

	// per-point sequencing
	localparam int WEIGHT_STEPS = 6;
	localparam int MUL_STEPS    = 4;
	localparam int BLEND_STEPS  = 5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_STEP,
		ST_WEIGHT,
		ST_BLEND,
		ST_EMIT
	} cbs_state_t;

	typedef enum logic [2:0] {
		WOP_U2,
		WOP_T2,
		WOP_W0,
		WOP_W1,
		WOP_W2,
		WOP_W3
	} wop_t;

	typedef struct packed {
		logic       load;
		logic       div_step;
		logic       t_step;
		logic       weight_en;
		wop_t       weight_op;
		logic       mul_en;
		logic [1:0] mul_k;
		logic       acc_clear;
		logic       acc_add;
		logic       emit;
		logic       last;
	} cbs_cmd_t;

endpackage

`default_nettype wire

@@ rtl/cbs_datapath.sv @@
// Datapath of the cubic Bezier segmenter: point store, step divider,
// parameter stepping, weight multiplier, blend MACs and output word.
// Depends on cbs_pkg; driven by cbs_controller through cbs_cmd_t.
`default_nettype none

module cbs_datapath import cbs_pkg::*; #(
	parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
	parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
	parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
	input  wire                            clk,
	input  wire cbs_cmd_t                  cmd,
	input  wire [$clog2(MAX_SEGMENTS+1)-1:0] seg_n,
	input  wire signed [COORD_WIDTH-1:0]   start_x,
	input  wire signed [COORD_WIDTH-1:0]   start_y,
	input  wire signed [COORD_WIDTH-1:0]   start_z,
	input  wire signed [COORD_WIDTH-1:0]   end_x,
	input  wire signed [COORD_WIDTH-1:0]   end_y,
	input  wire signed [COORD_WIDTH-1:0]   end_z,
	input  wire signed [COORD_WIDTH-1:0]   ctrl1_x,
	input  wire signed [COORD_WIDTH-1:0]   ctrl1_y,
	input  wire signed [COORD_WIDTH-1:0]   ctrl1_z,
	input  wire signed [COORD_WIDTH-1:0]   ctrl2_x,
	input  wire signed [COORD_WIDTH-1:0]   ctrl2_y,
	input  wire signed [COORD_WIDTH-1:0]   ctrl2_z,
	output logic signed [COORD_WIDTH-1:0]  seg_from_x,
	output logic signed [COORD_WIDTH-1:0]  seg_from_y,
	output logic signed [COORD_WIDTH-1:0]  seg_from_z,
	output logic signed [COORD_WIDTH-1:0]  seg_to_x,
	output logic signed [COORD_WIDTH-1:0]  seg_to_y,
	output logic signed [COORD_WIDTH-1:0]  seg_to_z,
	output logic                           last_segment
);

	localparam int C  = COORD_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int NW = $clog2(MAX_SEGMENTS + 1);
	localparam int WW = F + 2;
	localparam int PW = WW + 1 + C;
	localparam int AW = PW + 1;

	localparam logic [F:0] T_ONE = {1'b1, {F{1'b0}}};
	localparam logic signed [AW-1:0] MAXV = {{(AW-C+1){1'b0}}, {(C-1){1'b1}}};
	localparam logic signed [AW-1:0] MINV = ~MAXV;

	// point store: [axis][0 start, 1 ctrl1, 2 ctrl2, 3 end]
	logic signed [C-1:0]  pts_q [3][4];
	logic signed [C-1:0]  prev_q [3];
	logic signed [C-1:0]  from_q [3];
	logic signed [C-1:0]  to_q [3];
	logic                 last_q;

	// step divider and parameter stepping
	logic [NW-1:0]        rem_q;
	logic [F:0]           quo_q;
	logic [F:0]           dbits_q;
	logic [F:0]           t_q;
	logic [NW-1:0]        r_q;

	// weights
	logic [F:0]           u2_q;
	logic [F:0]           t2_q;
	logic [WW-1:0]        w_q [4];

	// blend
	logic signed [PW-1:0] prod_s1 [3];
	logic signed [AW-1:0] acc_q [3];

	logic [NW:0]          trial;
	logic                 trial_ge;
	logic [NW:0]          rsum;
	logic                 rsum_ge;
	logic [F:0]           u;
	logic [F+1:0]         wa;
	logic [F:0]           wb;
	logic [2*F+2:0]       wprod;
	logic [WW-1:0]        wres;
	logic [WW-1:0]        wsel;
	logic signed [C-1:0]  sat_val [3];

	function automatic logic signed [C-1:0] sat_coord(input logic signed [AW-1:0] v);
		logic signed [AW-1:0] sh;
		sh = v >>> F;
		if (sh > MAXV) begin
			sat_coord = MAXV[C-1:0];
		end else if (sh < MINV) begin
			sat_coord = MINV[C-1:0];
		end else begin
			sat_coord = sh[C-1:0];
		end
	endfunction

	assign trial    = {rem_q, dbits_q[F]};
	assign trial_ge = trial >= {1'b0, seg_n};
	assign rsum     = {1'b0, r_q} + {1'b0, rem_q};
	assign rsum_ge  = rsum >= {1'b0, seg_n};
	assign u        = T_ONE - t_q;
	assign wsel     = w_q[cmd.mul_k];

	always_comb begin
		case (cmd.weight_op)
			WOP_U2: begin
				wa = {1'b0, u};
				wb = u;
			end
			WOP_T2: begin
				wa = {1'b0, t_q};
				wb = t_q;
			end
			WOP_W0: begin
				wa = {1'b0, u2_q};
				wb = u;
			end
			WOP_W1: begin
				wa = ({1'b0, u2_q} << 1) + {1'b0, u2_q};
				wb = t_q;
			end
			WOP_W2: begin
				wa = ({1'b0, u} << 1) + {1'b0, u};
				wb = t2_q;
			end
			default: begin
				wa = {1'b0, t2_q};
				wb = t_q;
			end
		endcase
	end

	assign wprod = wa * wb;
	assign wres  = wprod[2*F+1:F];

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			sat_val[a] = sat_coord(acc_q[a]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pts_q[0][0] <= start_x;
			pts_q[1][0] <= start_y;
			pts_q[2][0] <= start_z;
			pts_q[0][1] <= ctrl1_x;
			pts_q[1][1] <= ctrl1_y;
			pts_q[2][1] <= ctrl1_z;
			pts_q[0][2] <= ctrl2_x;
			pts_q[1][2] <= ctrl2_y;
			pts_q[2][2] <= ctrl2_z;
			pts_q[0][3] <= end_x;
			pts_q[1][3] <= end_y;
			pts_q[2][3] <= end_z;
			// the curve passes exactly through its start point
			prev_q[0]   <= start_x;
			prev_q[1]   <= start_y;
			prev_q[2]   <= start_z;
			rem_q       <= '0;
			quo_q       <= '0;
			dbits_q     <= T_ONE;
			t_q         <= '0;
			r_q         <= '0;
		end

		// restoring division of one by the segment count
		if (cmd.div_step) begin
			rem_q   <= trial_ge ? NW'(trial - {1'b0, seg_n}) : trial[NW-1:0];
			quo_q   <= {quo_q[F-1:0], trial_ge};
			dbits_q <= {dbits_q[F-1:0], 1'b0};
		end

		// advance t by 1/N, carrying the remainder so t stays exact
		if (cmd.t_step) begin
			r_q <= rsum_ge ? NW'(rsum - {1'b0, seg_n}) : rsum[NW-1:0];
			t_q <= t_q + quo_q + {{F{1'b0}}, rsum_ge};
		end

		if (cmd.weight_en) begin
			case (cmd.weight_op)
				WOP_U2:  u2_q   <= wres[F:0];
				WOP_T2:  t2_q   <= wres[F:0];
				WOP_W0:  w_q[0] <= wres;
				WOP_W1:  w_q[1] <= wres;
				WOP_W2:  w_q[2] <= wres;
				default: w_q[3] <= wres;
			endcase
		end

		for (int a = 0; a < 3; a++) begin
			if (cmd.mul_en) begin
				prod_s1[a] <= $signed({1'b0, wsel}) * pts_q[a][cmd.mul_k];
			end
			if (cmd.acc_clear) begin
				acc_q[a] <= '0;
			end else if (cmd.acc_add) begin
				acc_q[a] <= acc_q[a] + {{(AW-PW){prod_s1[a][PW-1]}}, prod_s1[a]};
			end
			if (cmd.emit) begin
				from_q[a] <= prev_q[a];
				to_q[a]   <= sat_val[a];
				prev_q[a] <= sat_val[a];
			end
		end

		if (cmd.emit) begin
			last_q <= cmd.last;
		end
	end

	assign seg_from_x   = from_q[0];
	assign seg_from_y   = from_q[1];
	assign seg_from_z   = from_q[2];
	assign seg_to_x     = to_q[0];
	assign seg_to_y     = to_q[1];
	assign seg_to_z     = to_q[2];
	assign last_segment = last_q;

endmodule

`default_nettype wire

@@ rtl/cbs_controller.sv @@
// Controller of the cubic Bezier segmenter: segment count register,
// sequencing state machine and the output word handshake.
// Depends on cbs_pkg and cubic_bezier_segmenter_core_macros.svh.
`default_nettype none
`include "cubic_bezier_segmenter_core_macros.svh"

module cbs_controller import cbs_pkg::*; #(
	parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
	parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire [CFG_WIDTH-1:0]              cfg_data,
	input  wire                              in_valid,
	output logic                             in_ready,
	output logic                             out_valid,
	input  wire                              out_ready,
	output cbs_cmd_t                         cmd,
	output logic [$clog2(MAX_SEGMENTS+1)-1:0] seg_n
);

	localparam int NW    = $clog2(MAX_SEGMENTS + 1);
	localparam int CNT_W = $clog2(FRAC_BITS + 1);

	cbs_state_t            state_q, state_d;
	logic [CNT_W-1:0]      cnt_q, cnt_d;
	logic [NW-1:0]         seg_q, seg_d;
	logic [NW-1:0]         n_q, n_d;
	logic [CFG_WIDTH-1:0]  seg_cfg_q;
	logic                  out_valid_q, out_valid_d;
	logic                  emit_fire;
	logic                  seg_last;
	logic [NW-1:0]         n_clamped;

	assign cfg_ready = 1'b1;
	assign seg_n     = n_q;
	assign out_valid = out_valid_q;
	assign emit_fire = !out_valid_q || out_ready;
	assign seg_last  = ({1'b0, seg_q} + 1'b1) == {1'b0, n_q};

	always_comb begin
		if (seg_cfg_q == '0) begin
			n_clamped = NW'(1);
		end else if (seg_cfg_q > CFG_WIDTH'(MAX_SEGMENTS)) begin
			n_clamped = NW'(MAX_SEGMENTS);
		end else begin
			n_clamped = seg_cfg_q[NW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			seg_q       <= '0;
			n_q         <= NW'(1);
			seg_cfg_q   <= SEG_COUNT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			seg_q       <= seg_d;
			n_q         <= n_d;
			out_valid_q <= out_valid_d;
			if (cfg_valid && cfg_ready) begin
				seg_cfg_q <= cfg_data;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		seg_d    = seg_q;
		n_d      = n_q;
		cmd      = '0;
		in_ready = 1'b0;

		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					n_d      = n_clamped;
					seg_d    = '0;
					cnt_d    = '0;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_W'(FRAC_BITS)) begin
					cnt_d   = '0;
					state_d = ST_STEP;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_STEP: begin
				cmd.t_step = 1'b1;
				cnt_d      = '0;
				state_d    = ST_WEIGHT;
			end
			ST_WEIGHT: begin
				cmd.weight_en = 1'b1;
				case (cnt_q)
					CNT_W'(0): cmd.weight_op = WOP_U2;
					CNT_W'(1): cmd.weight_op = WOP_T2;
					CNT_W'(2): cmd.weight_op = WOP_W0;
					CNT_W'(3): cmd.weight_op = WOP_W1;
					CNT_W'(4): cmd.weight_op = WOP_W2;
					default:   cmd.weight_op = WOP_W3;
				endcase
				if (cnt_q == CNT_W'(WEIGHT_STEPS - 1)) begin
					cnt_d   = '0;
					state_d = ST_BLEND;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_BLEND: begin
				// product registered in the cycle before it is accumulated
				cmd.mul_en    = cnt_q < CNT_W'(MUL_STEPS);
				cmd.mul_k     = cnt_q[1:0];
				cmd.acc_clear = cnt_q == '0;
				cmd.acc_add   = cnt_q != '0;
				if (cnt_q == CNT_W'(BLEND_STEPS - 1)) begin
					cnt_d   = '0;
					state_d = ST_EMIT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_EMIT: begin
				// hold until the output word is free
				if (emit_fire) begin
					cmd.emit = 1'b1;
					cmd.last = seg_last;
					if (seg_last) begin
						state_d = ST_IDLE;
					end else begin
						seg_d   = seg_q + 1'b1;
						state_d = ST_STEP;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (cmd.emit) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	`CBS_ASSERT_NEXT(a_accept_starts_div, in_valid && in_ready, state_q == ST_DIV && seg_q == '0, "accepted curve did not start the divider")
	`CBS_ASSERT_SAME(a_seg_in_range, state_q != ST_IDLE, seg_q < n_q, "segment index reached the segment count")
	`CBS_ASSERT_SAME(a_count_legal, 1'b1, n_q != '0 && n_q <= NW'(MAX_SEGMENTS), "latched segment count out of range")
	`CBS_ASSERT_NEXT(a_last_goes_idle, state_q == ST_EMIT && emit_fire && seg_last, state_q == ST_IDLE && out_valid_q, "last segment did not end the curve")

endmodule

`default_nettype wire

@@ rtl/cubic_bezier_segmenter_core.sv @@
// Cubic Bezier segmenter: takes one curve (start, end, two control points,
// signed Q.FRAC_BITS) and emits segment_count line segments along it, one
// output word per segment with last_segment set on the final one. After a
// curve is accepted a restoring divider forms 1/N; each segment then runs
// a t step, six weight multiplies on one shared multiplier, a blend on three
// axis MACs and an output load. The output word is registered, so a new
// curve is accepted while the last segment still waits. segment_count is
// clamped to 1..MAX_SEGMENTS when a curve is accepted and is written through
// the cfg channel, which is always ready.
`default_nettype none

module cubic_bezier_segmenter_core import cbs_pkg::*; #(
	parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
	parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
	parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire [CFG_WIDTH-1:0]           cfg_data,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire signed [COORD_WIDTH-1:0]  start_x,
	input  wire signed [COORD_WIDTH-1:0]  start_y,
	input  wire signed [COORD_WIDTH-1:0]  start_z,
	input  wire signed [COORD_WIDTH-1:0]  end_x,
	input  wire signed [COORD_WIDTH-1:0]  end_y,
	input  wire signed [COORD_WIDTH-1:0]  end_z,
	input  wire signed [COORD_WIDTH-1:0]  ctrl1_x,
	input  wire signed [COORD_WIDTH-1:0]  ctrl1_y,
	input  wire signed [COORD_WIDTH-1:0]  ctrl1_z,
	input  wire signed [COORD_WIDTH-1:0]  ctrl2_x,
	input  wire signed [COORD_WIDTH-1:0]  ctrl2_y,
	input  wire signed [COORD_WIDTH-1:0]  ctrl2_z,
	output logic                          out_valid,
	input  wire                           out_ready,
	output logic signed [COORD_WIDTH-1:0] seg_from_x,
	output logic signed [COORD_WIDTH-1:0] seg_from_y,
	output logic signed [COORD_WIDTH-1:0] seg_from_z,
	output logic signed [COORD_WIDTH-1:0] seg_to_x,
	output logic signed [COORD_WIDTH-1:0] seg_to_y,
	output logic signed [COORD_WIDTH-1:0] seg_to_z,
	output logic                          last_segment
);

	localparam int NW = $clog2(MAX_SEGMENTS + 1);

	cbs_cmd_t      cmd;
	logic [NW-1:0] seg_n;

	cbs_controller #(
		.MAX_SEGMENTS (MAX_SEGMENTS),
		.FRAC_BITS    (FRAC_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.seg_n     (seg_n)
	);

	cbs_datapath #(
		.MAX_SEGMENTS (MAX_SEGMENTS),
		.COORD_WIDTH  (COORD_WIDTH),
		.FRAC_BITS    (FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.cmd          (cmd),
		.seg_n        (seg_n),
		.start_x      (start_x),
		.start_y      (start_y),
		.start_z      (start_z),
		.end_x        (end_x),
		.end_y        (end_y),
		.end_z        (end_z),
		.ctrl1_x      (ctrl1_x),
		.ctrl1_y      (ctrl1_y),
		.ctrl1_z      (ctrl1_z),
		.ctrl2_x      (ctrl2_x),
		.ctrl2_y      (ctrl2_y),
		.ctrl2_z      (ctrl2_z),
		.seg_from_x   (seg_from_x),
		.seg_from_y   (seg_from_y),
		.seg_from_z   (seg_from_z),
		.seg_to_x     (seg_to_x),
		.seg_to_y     (seg_to_y),
		.seg_to_z     (seg_to_z),
		.last_segment (last_segment)
	);

endmodule

`default_nettype wire
